[rtl/ecpad_pkg.sv]
// Shared types, constants and modular helpers for the elliptic curve point adder.
package ecpad_pkg;

   localparam int FB    = 32;
   localparam int CNT_W = $clog2(FB);
   localparam int ADDR_W = 3;

   localparam logic [FB-1:0] DBL_FACTOR = FB'(3);
   localparam logic [FB-1:0] DEN_FACTOR = FB'(2);
   localparam logic [FB-1:0] PRIME_RST  = FB'(23);
   localparam logic [FB-1:0] COEF_RST   = FB'(1);

   typedef enum logic [0:0] {
      REG_PRIME = 1'b0,
      REG_COEF  = 1'b1
   } reg_idx_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_INF   = 2'd1,
      STAT_NOINV = 2'd2
   } status_type;

   typedef struct packed {
      logic [FB-1:0] p_coord_x;
      logic [FB-1:0] p_coord_y;
      logic [FB-1:0] q_coord_x;
      logic [FB-1:0] q_coord_y;
   } req_type;

   typedef struct packed {
      logic [FB-1:0] sum_x;
      logic [FB-1:0] sum_y;
      logic [1:0]    add_status;
   } rsp_type;

   function automatic logic [FB-1:0] mod_add(input logic [FB-1:0] x, input logic [FB-1:0] y,
                                            input logic [FB-1:0] m);
      logic [FB:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[FB-1:0];
   endfunction

   // Operands below m: the wrapped difference plus m lands back in range.
   function automatic logic [FB-1:0] mod_sub(input logic [FB-1:0] x, input logic [FB-1:0] y,
                                            input logic [FB-1:0] m);
      logic [FB-1:0] d;
      d = x - y;
      if (x < y) d = d + m;
      return d;
   endfunction

endpackage

[rtl/ec_point_add_double.sv]
// Top level of the affine elliptic curve point adder and doubler over GF(p).
//
// Adds two affine points P and Q on y^2 = x^3 + a*x + b mod p, doubling when
// they are equal, and returns R with a status: ok, infinity (zero denominator)
// or not invertible (no inverse mod p, or p below two, where R reads as zero).
// One item is worked at a time by a single bit-serial unit that handles one
// bit per cycle for each modular reduction and multiplication, and the inverse
// runs extended Euclid with one long-division pass on that unit per remainder
// step (at most about 47 steps for 32-bit values). An item that ends at
// infinity skips the inverse, and a modulus below two goes straight to the
// result. A new item is taken while a finished result waits.
module ec_point_add_double (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ecpad_pkg::req_type      req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ecpad_pkg::rsp_type      rsp_data,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [ecpad_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [ecpad_pkg::FB-1:0] csr_pwdata,
   output logic [ecpad_pkg::FB-1:0] csr_prdata,
   output logic                    csr_pready
);
   import ecpad_pkg::*;

   typedef enum logic [17:0] {
      ST_IDLE = 18'h00001,
      ST_RED  = 18'h00002,
      ST_PICK = 18'h00004,
      ST_SQ   = 18'h00008,
      ST_TRI  = 18'h00010,
      ST_NUM  = 18'h00020,
      ST_DEN2 = 18'h00040,
      ST_CHK  = 18'h00080,
      ST_EUC  = 18'h00100,
      ST_INV  = 18'h00200,
      ST_LAM  = 18'h00400,
      ST_LSQ  = 18'h00800,
      ST_RX1  = 18'h01000,
      ST_RX2  = 18'h02000,
      ST_YD   = 18'h04000,
      ST_YM   = 18'h08000,
      ST_RY   = 18'h10000,
      ST_FIN  = 18'h20000
   } state_type;

   localparam logic [2:0]       RED_LAST = 3'd4;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FB - 1);

   state_type     state_ff, state_in;
   logic [FB-1:0] prime_ff, prime_in, coef_ff, coef_in;
   req_type       raw_ff, raw_in;
   logic [2:0]    red_ff, red_in;
   logic [FB-1:0] px_ff, px_in, py_ff, py_in, qx_ff, qx_in, qy_ff, qy_in, a_ff, a_in;
   logic [FB-1:0] num_ff, num_in, den_ff, den_in, tmp_ff, tmp_in, lam_ff, lam_in;
   logic [FB-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [FB-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [1:0]    st_ff, st_in;
   logic [FB-1:0] sh_ff, sh_in, x_ff, x_in, acc_ff, acc_in, rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic          ld_ff, ld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [FB-1:0] op_x, op_y, red_src;
   logic          bit_in, qbit, mbit, euc, ser_done, req_fire, csr_wr;
   logic [FB:0]   rr, dbl, dr, sum;
   logic [FB-1:0] rem_next, acc_next;

   assign req_fire   = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_COEF) ? coef_ff : prime_ff;

   always_comb begin
      case (red_ff)
         3'd0:    red_src = raw_ff.p_coord_x;
         3'd1:    red_src = raw_ff.p_coord_y;
         3'd2:    red_src = raw_ff.q_coord_x;
         3'd3:    red_src = raw_ff.q_coord_y;
         default: red_src = coef_ff;
      endcase
   end

   // Multiplicand and serial multiplier bits for each serial state.
   always_comb begin
      op_x = '0;
      op_y = '0;
      case (state_ff)
         ST_RED:  begin op_x = FB'(1); op_y = red_src;    end
         ST_SQ:   begin op_x = px_ff;  op_y = px_ff;      end
         ST_TRI:  begin op_x = tmp_ff; op_y = DBL_FACTOR; end
         ST_DEN2: begin op_x = py_ff;  op_y = DEN_FACTOR; end
         ST_EUC:  begin op_x = t1_ff;  op_y = r0_ff;      end
         ST_LAM:  begin op_x = t0_ff;  op_y = num_ff;     end
         ST_LSQ:  begin op_x = lam_ff; op_y = lam_ff;     end
         ST_YM:   begin op_x = lam_ff; op_y = tmp_ff;     end
         default: begin op_x = '0;     op_y = '0;         end
      endcase
   end

   // One bit per cycle: long-division step and double-and-add mod p.
   always_comb begin
      euc      = (state_ff == ST_EUC);
      bit_in   = sh_ff[FB-1];
      rr       = {rem_ff, bit_in};
      qbit     = (rr >= {1'b0, r1_ff});
      rem_next = qbit ? FB'(rr - {1'b0, r1_ff}) : rr[FB-1:0];
      mbit     = euc ? qbit : bit_in;
      dbl      = {acc_ff, 1'b0};
      dr       = (dbl >= {1'b0, prime_ff}) ? dbl - {1'b0, prime_ff} : dbl;
      sum      = dr + (mbit ? {1'b0, x_ff} : '0);
      acc_next = (sum >= {1'b0, prime_ff}) ? FB'(sum - {1'b0, prime_ff}) : sum[FB-1:0];
      ser_done = !ld_ff && (cnt_ff == CNT_LAST);
   end

   always_comb begin
      state_in = state_ff;
      prime_in = prime_ff;  coef_in = coef_ff;  raw_in = raw_ff;  red_in = red_ff;
      px_in = px_ff;  py_in = py_ff;  qx_in = qx_ff;  qy_in = qy_ff;  a_in = a_ff;
      num_in = num_ff;  den_in = den_ff;  tmp_in = tmp_ff;  lam_in = lam_ff;
      rx_in = rx_ff;  ry_in = ry_ff;  st_in = st_ff;
      r0_in = r0_ff;  r1_in = r1_ff;  t0_in = t0_ff;  t1_in = t1_ff;
      sh_in = sh_ff;  x_in = x_ff;  acc_in = acc_ff;  rem_in = rem_ff;
      cnt_in = cnt_ff;  ld_in = ld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;

      if (csr_wr) begin
         if (csr_paddr[2] == REG_PRIME) prime_in = csr_pwdata;
         else                           coef_in  = csr_pwdata;
      end

      if (state_ff == ST_RED || state_ff == ST_SQ || state_ff == ST_TRI ||
          state_ff == ST_DEN2 || state_ff == ST_EUC || state_ff == ST_LAM ||
          state_ff == ST_LSQ || state_ff == ST_YM) begin
         if (ld_ff) begin
            sh_in  = op_y;
            x_in   = op_x;
            acc_in = '0;
            rem_in = '0;
            cnt_in = '0;
            ld_in  = 1'b0;
         end else begin
            sh_in  = {sh_ff[FB-2:0], 1'b0};
            acc_in = acc_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + CNT_W'(1);
            if (ser_done) ld_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               raw_in = req_data;
               red_in = '0;
               rx_in  = '0;
               ry_in  = '0;
               if (prime_ff < FB'(2)) begin
                  st_in    = STAT_NOINV;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (ser_done) begin
               case (red_ff)
                  3'd0:    px_in = acc_next;
                  3'd1:    py_in = acc_next;
                  3'd2:    qx_in = acc_next;
                  3'd3:    qy_in = acc_next;
                  default: a_in  = acc_next;
               endcase
               red_in = red_ff + 3'd1;
               if (red_ff == RED_LAST) state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (px_ff == qx_ff && py_ff == qy_ff) begin
               state_in = ST_SQ;
            end else begin
               num_in   = mod_sub(qy_ff, py_ff, prime_ff);
               den_in   = mod_sub(qx_ff, px_ff, prime_ff);
               state_in = ST_CHK;
            end
         end
         ST_SQ: begin
            if (ser_done) begin
               tmp_in   = acc_next;
               state_in = ST_TRI;
            end
         end
         ST_TRI: begin
            if (ser_done) begin
               tmp_in   = acc_next;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            num_in   = mod_add(tmp_ff, a_ff, prime_ff);
            state_in = ST_DEN2;
         end
         ST_DEN2: begin
            if (ser_done) begin
               den_in   = acc_next;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (den_ff == '0) begin
               st_in    = STAT_INF;
               state_in = ST_FIN;
            end else begin
               r0_in    = prime_ff;
               r1_in    = den_ff;
               t0_in    = '0;
               t1_in    = FB'(1);
               state_in = ST_EUC;
            end
         end
         ST_EUC: begin
            // Advance the remainder sequence and the cofactor pair together.
            if (ser_done) begin
               r0_in = r1_ff;
               r1_in = rem_next;
               t0_in = t1_ff;
               t1_in = mod_sub(t0_ff, acc_next, prime_ff);
               if (rem_next == '0) state_in = ST_INV;
            end
         end
         ST_INV: begin
            if (r0_ff != FB'(1)) begin
               st_in    = STAT_NOINV;
               state_in = ST_FIN;
            end else begin
               state_in = ST_LAM;
            end
         end
         ST_LAM: begin
            if (ser_done) begin
               lam_in   = acc_next;
               state_in = ST_LSQ;
            end
         end
         ST_LSQ: begin
            if (ser_done) begin
               tmp_in   = acc_next;
               state_in = ST_RX1;
            end
         end
         ST_RX1: begin
            tmp_in   = mod_sub(tmp_ff, px_ff, prime_ff);
            state_in = ST_RX2;
         end
         ST_RX2: begin
            rx_in    = mod_sub(tmp_ff, qx_ff, prime_ff);
            state_in = ST_YD;
         end
         ST_YD: begin
            tmp_in   = mod_sub(px_ff, rx_ff, prime_ff);
            state_in = ST_YM;
         end
         ST_YM: begin
            if (ser_done) begin
               tmp_in   = acc_next;
               state_in = ST_RY;
            end
         end
         ST_RY: begin
            ry_in    = mod_sub(tmp_ff, py_ff, prime_ff);
            st_in    = STAT_OK;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Hold until the output slot is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.sum_x      = rx_ff;
               rsp_in.sum_y      = ry_ff;
               rsp_in.add_status = st_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prime_ff     <= PRIME_RST;
         coef_ff      <= COEF_RST;
         ld_ff        <= 1'b1;
         cnt_ff       <= '0;
         red_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prime_ff     <= prime_in;
         coef_ff      <= coef_in;
         ld_ff        <= ld_in;
         cnt_ff       <= cnt_in;
         red_ff       <= red_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
      px_ff  <= px_in;   py_ff  <= py_in;   qx_ff <= qx_in;  qy_ff <= qy_in;  a_ff <= a_in;
      num_ff <= num_in;  den_ff <= den_in;  tmp_ff <= tmp_in; lam_ff <= lam_in;
      rx_ff  <= rx_in;   ry_ff  <= ry_in;   st_ff <= st_in;
      r0_ff  <= r0_in;   r1_ff  <= r1_in;   t0_ff <= t0_in;  t1_ff <= t1_in;
      sh_ff  <= sh_in;   x_ff   <= x_in;    acc_ff <= acc_in; rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.add_status == STAT_OK || rsp_ff.add_status == STAT_INF ||
                        rsp_ff.add_status == STAT_NOINV))
      else $error("undefined status code on result");

   a_euc_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EUC) |-> (r1_ff != '0))
      else $error("Euclid step with zero divisor");

   a_euc_rem: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EUC) && !ld_ff) |-> (rem_ff < r1_ff))
      else $error("partial remainder not below divisor");

   a_inv_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAM) |-> (t0_ff < prime_ff))
      else $error("inverse not reduced below modulus");

endmodule
